// File: rtl/x86_status_flags_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef X86_STATUS_FLAGS_UNIT_MACROS_SVH
`define X86_STATUS_FLAGS_UNIT_MACROS_SVH

// Clocked check, off while reset is held.
`define X86SF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also runs through reset.
`define X86SF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/x86sf_pkg.sv
package x86sf_pkg;

  // Operation select carried on in_tuser
  localparam int FuncW = 3;
  typedef enum logic [FuncW-1:0] {
    FN_LOGIC = 3'd0,
    FN_ADD   = 3'd1,
    FN_SUB   = 3'd2,
    FN_COND  = 3'd3,
    FN_READ  = 3'd4,
    FN_WRITE = 3'd5
  } func_e;

  // Operand width codes
  typedef enum logic [1:0] {
    WC_8  = 2'd0,
    WC_16 = 2'd1,
    WC_32 = 2'd2,
    WC_64 = 2'd3
  } width_e;

  // Condition code bits 3..1
  typedef enum logic [2:0] {
    CC_O  = 3'd0,
    CC_C  = 3'd1,
    CC_Z  = 3'd2,
    CC_BE = 3'd3,
    CC_S  = 3'd4,
    CC_P  = 3'd5,
    CC_L  = 3'd6,
    CC_LE = 3'd7
  } cond_sel_e;

  localparam int WordW = 64;

  // Input tdata layout, lowest bit first
  localparam int WcLsb   = 0;
  localparam int ResLsb  = 2;
  localparam int LhsLsb  = ResLsb + WordW;
  localparam int RhsLsb  = LhsLsb + WordW;
  localparam int KeepBit = RhsLsb + WordW;
  localparam int ZeqBit  = KeepBit + 1;
  localparam int CcLsb   = ZeqBit + 1;
  localparam int WvLsb   = CcLsb + 4;
  localparam int InDataW = WvLsb + WordW;

  // Output tdata layout: condition_true, then flags_read_value, zero padded
  localparam int OutUsedW = 1 + WordW;
  localparam int OutDataW = ((OutUsedW + 7) / 8) * 8;

  // RFLAGS bit positions
  localparam int CfBit = 0;
  localparam int PfBit = 2;
  localparam int AfBit = 4;
  localparam int ZfBit = 6;
  localparam int SfBit = 7;
  localparam int DfBit = 10;
  localparam int OfBit = 11;
  localparam logic [WordW-1:0] RflagsBase = 64'h202;

  typedef struct packed {
    logic of;
    logic df;
    logic sf;
    logic zf;
    logic af;
    logic pf;
    logic cf;
  } flags_t;

endpackage

// File: rtl/x86_status_flags_unit.sv
// An accepted beat is held in the input register, then moves into the result register,
// which drives out_tvalid. Throughput: one beat per cycle while out_tready is high;
// the flag registers update as an item moves from the input register into the result
// register, so the next item sees them.
// in_tready stays high while the result register is empty or being drained.
// Reset (synchronous, rst_n low) clears all flags and both valid bits.
module x86_status_flags_unit import x86sf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // width_code, result_value, left_operand, right_operand, keep_carry,
  // zero_from_equality, condition_code, flags_write_value
  input  logic [InDataW-1:0]  in_tdata,
  // func
  input  logic [FuncW-1:0]    in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // condition_true, flags_read_value, zero pad
  output logic [OutDataW-1:0] out_tdata
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [InDataW-1:0]  s1_data_r;
  logic [FuncW-1:0]    s1_func_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  flags_t              flags_r, flags_nxt;

  logic       advance;
  logic       in_beat;

  width_e     wc;
  logic [WordW-1:0] mask, sb, res, lhs, rhs, wv, pack;
  logic       keep_c, alt_z;
  logic [3:0] cc;
  logic       res_zero, res_sign, res_par, res_af;
  logic       add_of, sub_lt_s;
  logic       cond_raw, cond_out;
  logic [WordW-1:0] read_out;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  // Field unpack
  always_comb begin
    wc     = width_e'(s1_data_r[WcLsb +: 2]);
    keep_c = s1_data_r[KeepBit];
    alt_z  = s1_data_r[ZeqBit];
    cc     = s1_data_r[CcLsb +: 4];
    wv     = s1_data_r[WvLsb +: WordW];
    unique case (wc)
      WC_8: begin
        mask = 64'h0000_0000_0000_00FF;
        sb   = 64'h0000_0000_0000_0080;
      end
      WC_16: begin
        mask = 64'h0000_0000_0000_FFFF;
        sb   = 64'h0000_0000_0000_8000;
      end
      WC_32: begin
        mask = 64'h0000_0000_FFFF_FFFF;
        sb   = 64'h0000_0000_8000_0000;
      end
      default: begin
        mask = 64'hFFFF_FFFF_FFFF_FFFF;
        sb   = 64'h8000_0000_0000_0000;
      end
    endcase
    res = s1_data_r[ResLsb +: WordW] & mask;
    lhs = s1_data_r[LhsLsb +: WordW] & mask;
    rhs = s1_data_r[RhsLsb +: WordW] & mask;
  end

  // Common flag terms
  always_comb begin
    res_zero = (res == '0);
    res_sign = |(res & sb);
    res_par  = ~^res[7:0];
    res_af   = res[4] ^ lhs[4] ^ rhs[4];
    add_of   = |(~(lhs ^ rhs) & (res ^ lhs) & sb);
    // flip the sign bit so an unsigned compare orders signed values
    sub_lt_s = (lhs ^ sb) < (rhs ^ sb);
  end

  // Condition evaluation and flags word
  always_comb begin
    unique case (cond_sel_e'(cc[3:1]))
      CC_O:  cond_raw = flags_r.of;
      CC_C:  cond_raw = flags_r.cf;
      CC_Z:  cond_raw = flags_r.zf;
      CC_BE: cond_raw = flags_r.cf || flags_r.zf;
      CC_S:  cond_raw = flags_r.sf;
      CC_P:  cond_raw = flags_r.pf;
      CC_L:  cond_raw = flags_r.sf ^ flags_r.of;
      CC_LE: cond_raw = flags_r.zf || (flags_r.sf ^ flags_r.of);
    endcase
    pack        = RflagsBase;
    pack[CfBit] = flags_r.cf;
    pack[PfBit] = flags_r.pf;
    pack[AfBit] = flags_r.af;
    pack[ZfBit] = flags_r.zf;
    pack[SfBit] = flags_r.sf;
    pack[DfBit] = flags_r.df;
    pack[OfBit] = flags_r.of;
  end

  // Per-operation update
  always_comb begin
    flags_nxt = flags_r;
    cond_out  = 1'b0;
    read_out  = '0;
    unique case (func_e'(s1_func_r))
      FN_LOGIC: begin
        flags_nxt.sf = res_sign;
        flags_nxt.pf = res_par;
        flags_nxt.af = 1'b0;
      end
      FN_ADD: begin
        flags_nxt.zf = res_zero;
        flags_nxt.sf = res_sign;
        flags_nxt.pf = res_par;
        flags_nxt.af = res_af;
        if (!keep_c) begin
          flags_nxt.cf = res < lhs;
        end
        flags_nxt.of = add_of;
      end
      FN_SUB: begin
        flags_nxt.zf = alt_z ? (lhs == rhs) : res_zero;
        flags_nxt.sf = res_sign;
        flags_nxt.pf = res_par;
        flags_nxt.af = res_af;
        if (!keep_c) begin
          flags_nxt.cf = lhs < rhs;
        end
        flags_nxt.of = res_sign ^ sub_lt_s;
      end
      FN_COND: begin
        cond_out = cond_raw ^ cc[0];
      end
      FN_READ: begin
        read_out = pack & mask;
      end
      FN_WRITE: begin
        flags_nxt.cf = wv[CfBit];
        flags_nxt.pf = wv[PfBit];
        flags_nxt.af = wv[AfBit];
        flags_nxt.zf = wv[ZfBit];
        flags_nxt.sf = wv[SfBit];
        // DF and OF sit above an 8-bit word
        if (wc != WC_8) begin
          flags_nxt.df = wv[DfBit];
          flags_nxt.of = wv[OfBit];
        end
      end
      default: ;
    endcase
    out_data_nxt = {(OutDataW - OutUsedW)'(0), read_out, cond_out};
  end

  always_comb begin
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_data_r <= in_tdata;
      s1_func_r <= in_tuser;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/x86sf_checker.sv
`include "x86_status_flags_unit_macros.svh"

module x86sf_checker import x86sf_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // a beat on the output side stays put while stalled
  `X86SF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "out beat changed while stalled")

  `X86SF_ASSERT_RST(a_rst_clear, !rst_n |=> !out_tvalid, "out_tvalid set right after reset")

  // input side never blocks while the result register is empty
  `X86SF_ASSERT(a_ready_empty, !out_tvalid |-> in_tready, "input stalled with empty output")

  // condition result and flags word never both nonzero
  `X86SF_ASSERT(a_one_kind, out_tvalid |-> !(out_tdata[0] && out_tdata[64:1] != '0), "both result fields set")

  // flags word lives in out_tdata bits 12..1, everything above is zero
  `X86SF_ASSERT(a_high_zero, out_tvalid |-> out_tdata[OutDataW-1:13] == '0, "bits above RFLAGS word set")

endmodule

bind x86_status_flags_unit x86sf_checker u_x86sf_checker (.*);
